>>> design/binary_to_decimal_ascii_macros.svh
// Assertion helpers used by binary_to_decimal_ascii to check itself.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bda_pkg.sv
package bda_pkg;

  localparam int VALUE_BITS      = 64;
  localparam int CHAR_BITS       = 6;
  localparam int DIGIT_BITS      = 4;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int ASCII_ZERO      = 48;

  localparam int STEP_BITS = 2;
  localparam int NUM_STEPS = 4;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_LOAD   = step_t'(0);
  localparam step_t STEP_DABBLE = step_t'(1);
  localparam step_t STEP_SKIP   = step_t'(2);
  localparam step_t STEP_EMIT   = step_t'(3);

  // Datapath operation selected by a control word.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_EMIT
  } op_t;

  // Condition under which a step holds instead of moving on.
  typedef enum logic [1:0] {
    COND_WAIT_INPUT,
    COND_BITS_LEFT,
    COND_LEAD_ZERO,
    COND_DIGITS_LEFT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t hold;
    step_t next;
  } uword_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic accepted;
    logic bits_left;
    logic lead_zero;
    logic digits_left;
  } status_t;

  // Control store: take a word, shift-add-3 over every bit, drop leading
  // zeros, then send one character per remaining digit.
  localparam uword_t PROGRAM [NUM_STEPS] = '{
    '{op: OP_LOAD,   hold: COND_WAIT_INPUT,  next: STEP_DABBLE},
    '{op: OP_DABBLE, hold: COND_BITS_LEFT,   next: STEP_SKIP},
    '{op: OP_SKIP,   hold: COND_LEAD_ZERO,   next: STEP_EMIT},
    '{op: OP_EMIT,   hold: COND_DIGITS_LEFT, next: STEP_LOAD}
  };

endpackage

>>> design/bda_ifs.sv
interface bda_in_if;
  logic                           valid;
  logic                           ready;
  logic [bda_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bda_out_if;
  logic                          valid;
  logic                          ready;
  logic [bda_pkg::CHAR_BITS-1:0] digit_char;
  logic                          last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> design/binary_to_decimal_ascii.sv
// Converts one unsigned binary word into decimal ASCII characters, most
// significant digit first with no leading zeros, and marks the final digit
// with last; zero gives the single character '0'. Only the low VALUE_WIDTH
// bits of value are used. A small control store steps a shift-add-3 datapath:
// it takes the word, converts it one bit per cycle over all VALUE_WIDTH bits,
// scans past the leading zero digits, then sends each character as the
// output register frees up. NDIG is 20 at a width of 64. A new word is taken
// as soon as the final character sits in the output register.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bda_in_if.sink    in_ch,
  bda_out_if.source out_ch
);
  import bda_pkg::*;
  `include "binary_to_decimal_ascii_macros.svh"

  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_BITS = NDIG * DIGIT_BITS;
  localparam int CNT_BITS = $clog2(VALUE_WIDTH);
  localparam int IDX_BITS = $clog2(NDIG);

  op_t     op;
  status_t status;

  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic [CNT_BITS-1:0]    bit_cnt;
  logic [IDX_BITS-1:0]    idx;
  logic [DIGIT_BITS-1:0]  cur_digit;

  logic                 out_valid;
  logic [CHAR_BITS-1:0] out_char;
  logic                 out_last;

  logic accept;
  logic emit_fire;

  bda_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  assign in_ch.ready = (op == OP_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cur_digit   = bcd[idx*DIGIT_BITS +: DIGIT_BITS];
  assign emit_fire   = (op == OP_EMIT) && (!out_valid || out_ch.ready);

  assign status.accepted    = accept;
  assign status.bits_left   = (bit_cnt != '0);
  assign status.lead_zero   = (cur_digit == '0) && (idx != '0);
  assign status.digits_left = !(emit_fire && (idx == '0));

  // Add 3 to every digit of five or more ahead of the shift.
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
        bcd_adj[d*DIGIT_BITS +: DIGIT_BITS] =
          bcd[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
      end else begin
        bcd_adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd[d*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  // Datapath registers driven by the current control word.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (accept) begin
          bin     <= in_ch.value[VALUE_WIDTH-1:0];
          bcd     <= '0;
          bit_cnt <= CNT_BITS'(VALUE_WIDTH - 1);
          idx     <= IDX_BITS'(NDIG - 1);
        end
      end
      OP_DABBLE: begin
        bcd     <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_WIDTH-1]};
        bin     <= {bin[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - CNT_BITS'(1);
      end
      OP_SKIP: begin
        if (status.lead_zero) begin
          idx <= idx - IDX_BITS'(1);
        end
      end
      OP_EMIT: begin
        if (emit_fire && (idx != '0)) begin
          idx <= idx - IDX_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load a word on emit, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_char <= CHAR_BITS'(ASCII_ZERO) + CHAR_BITS'(cur_digit);
      out_last <= (idx == '0);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.digit_char = out_char;
  assign out_ch.last       = out_last;

  `BDA_ASSERT_NEXT(a_accept_starts_conv, clk, rst, accept, op == OP_DABBLE, "no conversion after accept")
  `BDA_ASSERT_NOW(a_accept_after_last, clk, rst, accept, !out_valid || out_last, "word taken mid-run")
  `BDA_ASSERT_NOW(a_char_is_digit, clk, rst, out_valid, (out_char >= CHAR_BITS'(ASCII_ZERO)) && (out_char <= CHAR_BITS'(ASCII_ZERO + 9)), "character is not a digit")

endmodule

>>> design/bda_sequencer.sv
module bda_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  bda_pkg::status_t status,
  output bda_pkg::op_t     op
);
  import bda_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uword;
  logic   hold;

  assign uword = PROGRAM[pc];
  assign op    = uword.op;

  // Evaluate the hold condition of the current step.
  always_comb begin
    unique case (uword.hold)
      COND_WAIT_INPUT:  hold = !status.accepted;
      COND_BITS_LEFT:   hold = status.bits_left;
      COND_LEAD_ZERO:   hold = status.lead_zero;
      COND_DIGITS_LEFT: hold = status.digits_left;
      default:          hold = 1'b0;
    endcase
  end

  assign pc_next = hold ? pc : uword.next;

  // Advance the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> tb/bda_digit_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the digit characters of every accepted word
// and compares each accepted character against the oldest one predicted.
module bda_digit_checker #(
  parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bda_in_if         in_mon,
  bda_out_if        out_mon,
  output int        fail_count,
  output int        pending
);
  import bda_pkg::*;

  localparam int MAX_DIGITS = 20;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
  } char_word_t;

  char_word_t digit_q[$];
  int         errors = 0;

  // Split the masked value into decimal digits, then queue them most
  // significant first with last on the units digit.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    logic [DIGIT_BITS-1:0] digs[MAX_DIGITS];
    int                    n;
    char_word_t            w;
    rest = value & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - VALUE_WIDTH));
    n = 0;
    do begin
      digs[n] = DIGIT_BITS'(rest % 10);
      rest    = rest / 10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      w.digit_char = CHAR_BITS'(ASCII_ZERO + digs[k]);
      w.last       = (k == 0);
      digit_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    char_word_t want;
    if (!rst) begin
      // Check the character leaving the block first, then queue new digits
      if (out_mon.valid && out_mon.ready) begin
        if (digit_q.size() == 0) begin
          $display("%0t: unexpected word digit_char=%0d last=%0b", $time,
                   out_mon.digit_char, out_mon.last);
          errors++;
        end else begin
          want = digit_q.pop_front();
          if (out_mon.digit_char !== want.digit_char) begin
            $display("%0t: digit_char mismatch: expected %0d, actual %0d", $time,
                     want.digit_char, out_mon.digit_char);
            errors++;
          end
          if (out_mon.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                     want.last, out_mon.last);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_digits(in_mon.value);
    end
    fail_count <= errors;
    pending    <= digit_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bda_pkg::*;

  localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam int RANDOM_WORDS = 340;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 500;
  localparam int CALM_START   = 9000;
  localparam int CALM_END     = 15000;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bda_digit_checker #(.VALUE_WIDTH(VALUE_WIDTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Offer one word, optionally after a random idle gap, and hold it until
  // taken
  task automatic send_value(input logic [VALUE_BITS-1:0] value, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 99) < 6)
      gap = $urandom_range(40, 140);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stimulus: decimal boundaries and bit patterns first, then random words
  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] pow;
    int                    len;
    directed = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1000000000,
      64'hFFFF_FFFF, 64'd999999999999999999, 64'd1000000000000000000,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'd12345678901234567890, 64'd1234567890123456789,
      64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFF_FFFF_FFFF, 64'd0
    };
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_value(directed[i], 1'b1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        // Land on or just below a power of ten
        pow = 1;
        repeat ($urandom_range(1, 19)) pow = pow * 10;
        value = pow - VALUE_BITS'($urandom_range(0, 1));
      end else begin
        // Random bit length spreads the digit count
        len   = $urandom_range(1, VALUE_BITS);
        value = {$urandom, $urandom};
        value = value & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - len));
      end
      send_value(value, !(n >= 120 && n < 220));
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow the block to settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("binary_to_decimal_ascii test passed");
    else
      $display("binary_to_decimal_ascii test failed");
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    int rcv_cycle;
    rcv_cycle = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      rcv_cycle++;
      if (rcv_cycle == HOLD_START) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_cycle += HOLD_CYCLES;
      end else if (rcv_cycle >= CALM_START && rcv_cycle < CALM_END) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("binary_to_decimal_ascii test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
